@@ hw/rtl/pws_pkg.sv @@
package pws_pkg;

  localparam int unsigned NUM_COEFS = 12;
  localparam int unsigned DIM_W     = 13;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic FUNC_LOAD    = 1'b0;
  localparam logic FUNC_PROJECT = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'b1;

  localparam logic [DIM_W-1:0] WIDTH_RST  = 13'd800;
  localparam logic [DIM_W-1:0] HEIGHT_RST = 13'd600;

  localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic               func;
    logic [3:0]         coef_index;
    logic signed [31:0] coef_value;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } pws_in_t;

  typedef struct packed {
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
    logic signed [31:0] clip_w;
    logic               in_front;
    logic               w_zero;
  } pws_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_ROW,
    ST_CHECK,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_MAP_MUL,
    ST_MAP_ADD,
    ST_DONE
  } pws_state_e;

  typedef struct packed {
    logic       idle;
    logic       mul_clip;
    logic       acc_add;
    logic       row_end;
    logic       div_start;
    logic       mul_map;
    logic       map_add;
    logic       out_load;
    logic       axis;
    logic [3:0] slot;
  } pws_ctrl_t;

  typedef struct packed {
    logic proj_req;
    logic cw_zero;
    logic div_done;
    logic out_free;
  } pws_stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = S32_MAX;
    end else if (v < -64'sd2147483648) begin
      r = S32_MIN;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/pws_div.sv @@
module pws_div #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [31:0] num_i,
  input  logic signed [31:0] den_i,
  output logic               done_o,
  output logic signed [31:0] quot_o
);

  localparam int unsigned DW    = 32 + FRAC_BITS;
  localparam int unsigned CNT_W = $clog2(DW);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [31:0]       rem_q, rem_d;
  logic [DW-1:0]     dvd_q, dvd_d;
  logic [31:0]       den_q, den_d;
  logic              neg_q, neg_d;

  logic [31:0] num_mag, den_mag;
  logic [32:0] rem_sh, diff;
  logic        ge;
  logic        hi, big_neg;

  assign num_mag = num_i[31] ? 32'(-num_i) : num_i;
  assign den_mag = den_i[31] ? 32'(-den_i) : den_i;

  // one quotient bit per cycle
  assign rem_sh = {rem_q, dvd_q[DW-1]};
  assign diff   = rem_sh - {1'b0, den_q};
  assign ge     = (rem_sh >= {1'b0, den_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    den_d  = den_q;
    neg_d  = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dvd_d  = {num_mag, {FRAC_BITS{1'b0}}};
      den_d  = den_mag;
      neg_d  = num_i[31] ^ den_i[31];
    end else if (busy_q) begin
      rem_d = ge ? diff[31:0] : rem_sh[31:0];
      dvd_d = {dvd_q[DW-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(DW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  // saturate the signed quotient
  assign hi      = |dvd_q[DW-1:31];
  assign big_neg = hi && !((dvd_q[DW-1:32] == '0) && (dvd_q[30:0] == '0));

  always_comb begin
    if (neg_q) begin
      quot_o = big_neg ? pws_pkg::S32_MIN : $signed(32'(-dvd_q[31:0]));
    end else begin
      quot_o = hi ? pws_pkg::S32_MAX : $signed(dvd_q[31:0]);
    end
  end

  assign done_o = done_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) start_i |-> !busy_q)
    else $error("divider started while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |-> !busy_q)
    else $error("divider done while still stepping");
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |=> !done_q)
    else $error("divider done longer than one cycle");

endmodule

@@ hw/rtl/pws_ctrl.sv @@
module pws_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pws_pkg::pws_stat_t  stat_i,
  output pws_pkg::pws_ctrl_t  ctrl_o
);

  pws_pkg::pws_state_e state_q, state_d;
  logic [3:0]          slot_q, slot_d;
  logic                axis_q, axis_d;

  always_comb begin
    state_d = state_q;
    slot_d  = slot_q;
    axis_d  = axis_q;
    case (state_q)
      pws_pkg::ST_IDLE: begin
        if (stat_i.proj_req) begin
          state_d = pws_pkg::ST_MUL;
          slot_d  = '0;
        end
      end
      pws_pkg::ST_MUL: begin
        state_d = pws_pkg::ST_ACC;
      end
      pws_pkg::ST_ACC: begin
        slot_d  = slot_q + 4'd1;
        state_d = (slot_q[1:0] == 2'd2) ? pws_pkg::ST_ROW : pws_pkg::ST_MUL;
      end
      pws_pkg::ST_ROW: begin
        slot_d  = slot_q + 4'd1;
        state_d = (slot_q[3:2] == 2'd2) ? pws_pkg::ST_CHECK : pws_pkg::ST_MUL;
      end
      pws_pkg::ST_CHECK: begin
        axis_d  = 1'b0;
        state_d = stat_i.cw_zero ? pws_pkg::ST_DONE : pws_pkg::ST_DIV_GO;
      end
      pws_pkg::ST_DIV_GO: begin
        state_d = pws_pkg::ST_DIV_WAIT;
      end
      pws_pkg::ST_DIV_WAIT: begin
        if (stat_i.div_done) begin
          state_d = pws_pkg::ST_MAP_MUL;
        end
      end
      pws_pkg::ST_MAP_MUL: begin
        state_d = pws_pkg::ST_MAP_ADD;
      end
      pws_pkg::ST_MAP_ADD: begin
        if (!axis_q) begin
          axis_d  = 1'b1;
          state_d = pws_pkg::ST_DIV_GO;
        end else begin
          state_d = pws_pkg::ST_DONE;
        end
      end
      pws_pkg::ST_DONE: begin
        if (stat_i.out_free) begin
          state_d = pws_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = pws_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ctrl_o          = '0;
    ctrl_o.axis     = axis_q;
    ctrl_o.slot     = slot_q;
    case (state_q)
      pws_pkg::ST_IDLE:     ctrl_o.idle      = 1'b1;
      pws_pkg::ST_MUL:      ctrl_o.mul_clip  = 1'b1;
      pws_pkg::ST_ACC:      ctrl_o.acc_add   = 1'b1;
      pws_pkg::ST_ROW:      ctrl_o.row_end   = 1'b1;
      pws_pkg::ST_DIV_GO:   ctrl_o.div_start = 1'b1;
      pws_pkg::ST_MAP_MUL:  ctrl_o.mul_map   = 1'b1;
      pws_pkg::ST_MAP_ADD:  ctrl_o.map_add   = 1'b1;
      pws_pkg::ST_DONE:     ctrl_o.out_load  = stat_i.out_free;
      default:              ctrl_o.idle      = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pws_pkg::ST_IDLE;
      slot_q  <= '0;
      axis_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      slot_q  <= slot_d;
      axis_q  <= axis_d;
    end
  end

endmodule

@@ hw/rtl/perspective_world_to_screen.sv @@
// channel | direction | handshake                      | payload
// in      | input     | in_valid_i / in_stall_o         | in_word_i  (pws_in_t)
// out     | output    | out_valid_o / out_stall_i       | out_word_o (pws_out_t)
// cfg     | input     | cfg_we_i, cfg_idx_i, cfg_data_i | width, height
//
// a load word is written as it is accepted; a point (Q16.16 at FRAC_BITS 16)
// runs nine multiply-accumulate steps on the one shared multiplier and then,
// unless w is zero, the one-bit-per-cycle divider and a map multiply-add per axis
// asynchronous low reset clears the coefficients, sets 800x600, empties output
// in_stall_o is high while a point is in work or its result waits for the
// output register; the output register holds a result while out_stall_i is high
module perspective_world_to_screen #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  pws_pkg::pws_in_t                     in_word_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output pws_pkg::pws_out_t                    out_word_o,
  input  logic                                 cfg_we_i,
  input  logic [pws_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [pws_pkg::DIM_W-1:0]            cfg_data_i
);

  localparam logic signed [63:0] ONE   = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [31:0] W_THR = 32'(((64'd1 << FRAC_BITS) + 64'd99) / 64'd100);

  pws_pkg::pws_ctrl_t ctrl;
  pws_pkg::pws_stat_t stat;

  logic signed [31:0] coef_q [pws_pkg::NUM_COEFS];
  logic [pws_pkg::DIM_W-1:0] width_q, height_q;
  logic signed [31:0] px_q, py_q, pz_q;
  logic signed [31:0] cx_q, cy_q, cw_q;
  logic signed [31:0] sx_q, sy_q;
  logic signed [63:0] prod_q, acc_q;
  logic               out_valid_q;
  pws_pkg::pws_out_t  out_word_q;

  logic               in_acc, out_acc;
  logic               div_done;
  logic signed [31:0] coef_rd, pos_rd;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic signed [63:0] row_sum, map_sum;
  logic signed [31:0] quot;
  logic signed [31:0] row_clip;
  logic [pws_pkg::DIM_W-1:0] dim;

  assign in_stall_o = !ctrl.idle;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = out_valid_q && !out_stall_i;

  always_comb begin
    stat.proj_req = in_valid_i && (in_word_i.func == pws_pkg::FUNC_PROJECT);
    stat.cw_zero  = (cw_q == 32'sd0);
    stat.div_done = div_done;
    stat.out_free = !out_valid_q || !out_stall_i;
  end

  pws_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  pws_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ctrl.div_start),
    .num_i   (ctrl.axis ? cy_q : cx_q),
    .den_i   (cw_q),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  // coefficient store and viewport registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < pws_pkg::NUM_COEFS; i++) begin
        coef_q[i] <= '0;
      end
      width_q  <= pws_pkg::WIDTH_RST;
      height_q <= pws_pkg::HEIGHT_RST;
    end else begin
      if (in_acc && (in_word_i.func == pws_pkg::FUNC_LOAD) &&
          (in_word_i.coef_index < 4'(pws_pkg::NUM_COEFS))) begin
        coef_q[in_word_i.coef_index] <= in_word_i.coef_value;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          pws_pkg::CFG_WIDTH:  width_q  <= cfg_data_i;
          pws_pkg::CFG_HEIGHT: height_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  assign coef_rd = coef_q[ctrl.slot];

  always_comb begin
    case (ctrl.slot[1:0])
      2'd0:    pos_rd = px_q;
      2'd1:    pos_rd = py_q;
      2'd2:    pos_rd = pz_q;
      default: pos_rd = '0;
    endcase
  end

  // shared multiplier
  assign dim   = ctrl.axis ? height_q : width_q;
  assign mul_a = ctrl.mul_map ? 33'(quot) : 33'(coef_rd);
  assign mul_b = ctrl.mul_map ? $signed({20'b0, dim}) : 33'(pos_rd);
  assign mul_p = mul_a * mul_b;

  assign row_sum  = acc_q + 64'(coef_rd);
  assign row_clip = pws_pkg::sat32(row_sum);

  always_comb begin
    if (!ctrl.axis) begin
      map_sum = ($signed({51'b0, width_q}) <<< FRAC_BITS) + prod_q + ONE;
    end else begin
      map_sum = ($signed({51'b0, height_q}) <<< FRAC_BITS) - prod_q - ONE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      px_q <= in_word_i.pos_x;
      py_q <= in_word_i.pos_y;
      pz_q <= in_word_i.pos_z;
    end
    if (ctrl.mul_clip || ctrl.mul_map) begin
      prod_q <= mul_p[63:0];
    end
    if (ctrl.idle || ctrl.row_end) begin
      acc_q <= '0;
    end else if (ctrl.acc_add) begin
      acc_q <= acc_q + (prod_q >>> FRAC_BITS);
    end
    if (ctrl.row_end) begin
      case (ctrl.slot[3:2])
        2'd0:    cx_q <= row_clip;
        2'd1:    cy_q <= row_clip;
        default: cw_q <= row_clip;
      endcase
    end
    if (ctrl.map_add) begin
      if (!ctrl.axis) begin
        sx_q <= pws_pkg::sat32(map_sum >>> 1);
      end else begin
        sy_q <= pws_pkg::sat32(map_sum >>> 1);
      end
    end
    if (ctrl.out_load) begin
      out_word_q.clip_w   <= cw_q;
      out_word_q.in_front <= (cw_q >= W_THR);
      out_word_q.w_zero   <= stat.cw_zero;
      if (stat.cw_zero) begin
        out_word_q.screen_x <= cx_q[31] ? pws_pkg::S32_MIN : pws_pkg::S32_MAX;
        out_word_q.screen_y <= cy_q[31] ? pws_pkg::S32_MAX : pws_pkg::S32_MIN;
      end else begin
        out_word_q.screen_x <= sx_q;
        out_word_q.screen_y <= sy_q;
      end
    end
  end

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_acc) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.out_load |-> (!out_valid_q || !out_stall_i))
    else $error("result word overwritten while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_word_q.w_zero && out_word_q.in_front))
    else $error("zero w flagged in front");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(out_word_q)))
    else $error("stalled result word changed");

endmodule

@@ tb/sv/perspective_world_to_screen_tb.sv @@
`timescale 1ns / 100ps

module perspective_world_to_screen_tb;

  localparam int unsigned FRAC = 16;
  localparam int unsigned SETTLE_CYCLES = 160;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned RANDOM_WORDS = 1300;
  localparam logic signed [31:0] ONE_Q = 32'sh0001_0000;
  localparam logic signed [31:0] HALF_Q = 32'sh0000_8000;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  pws_pkg::pws_in_t in_word_i;
  logic out_valid_o;
  logic out_stall_i;
  pws_pkg::pws_out_t out_word_o;
  logic cfg_we_i;
  logic [pws_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [pws_pkg::DIM_W-1:0] cfg_data_i;

  logic signed [31:0] view_coef [pws_pkg::NUM_COEFS];
  logic [pws_pkg::DIM_W-1:0] view_width;
  logic [pws_pkg::DIM_W-1:0] view_height;
  pws_pkg::pws_out_t pending_screen_q[$];

  int unsigned send_idle_max;
  int unsigned take_idle_max;
  int unsigned stall_left;
  int unsigned cycle_count;
  int unsigned errors;
  int unsigned points_sent;
  int unsigned loads_sent;
  int unsigned viewports_set;

  perspective_world_to_screen #(
    .FRAC_BITS(FRAC)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic longint clamp_s32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // one row of the view matrix applied to (x, y, z, 1), products floored
  function automatic longint clip_sum(int unsigned row, longint px, longint py, longint pz);
    longint acc;
    acc = longint'(view_coef[row*4+3]);
    acc += (longint'(view_coef[row*4]) * px) >>> FRAC;
    acc += (longint'(view_coef[row*4+1]) * py) >>> FRAC;
    acc += (longint'(view_coef[row*4+2]) * pz) >>> FRAC;
    return clamp_s32(acc);
  endfunction

  function automatic pws_pkg::pws_out_t project_point(pws_pkg::pws_in_t word);
    pws_pkg::pws_out_t res;
    longint px, py, pz, cx, cy, cw, one, wd, ht, nx, ny, sx, sy, thr;
    px = longint'(word.pos_x);
    py = longint'(word.pos_y);
    pz = longint'(word.pos_z);
    cx = clip_sum(0, px, py, pz);
    cy = clip_sum(1, px, py, pz);
    cw = clip_sum(2, px, py, pz);
    one = 64'sd1 <<< FRAC;
    wd = longint'(view_width);
    ht = longint'(view_height);
    thr = (one + 99) / 100;
    if (cw == 0) begin
      sx = (cx >= 0) ? 64'sd2147483647 : -64'sd2147483648;
      sy = (cy >= 0) ? -64'sd2147483648 : 64'sd2147483647;
    end else begin
      nx = clamp_s32((cx * one) / cw);
      ny = clamp_s32((cy * one) / cw);
      sx = clamp_s32((wd * one + nx * wd + one) >>> 1);
      sy = clamp_s32((ht * one - ny * ht - one) >>> 1);
    end
    res.screen_x = sx[31:0];
    res.screen_y = sy[31:0];
    res.clip_w = cw[31:0];
    res.in_front = (cw >= thr);
    res.w_zero = (cw == 0);
    return res;
  endfunction

  function automatic void absorb_word(pws_pkg::pws_in_t word);
    if (word.func == pws_pkg::FUNC_LOAD) begin
      loads_sent++;
      if (word.coef_index < pws_pkg::NUM_COEFS) view_coef[word.coef_index] = word.coef_value;
    end else begin
      points_sent++;
      pending_screen_q.push_back(project_point(word));
    end
  endfunction

  function automatic void check_result(pws_pkg::pws_out_t got);
    pws_pkg::pws_out_t want;
    if (pending_screen_q.size() == 0) begin
      $error("result word with no projection pending");
      errors++;
      return;
    end
    want = pending_screen_q.pop_front();
    if (got.screen_x !== want.screen_x) begin
      $error("screen_x: expected %0d, got %0d", want.screen_x, got.screen_x);
      errors++;
    end
    if (got.screen_y !== want.screen_y) begin
      $error("screen_y: expected %0d, got %0d", want.screen_y, got.screen_y);
      errors++;
    end
    if (got.clip_w !== want.clip_w) begin
      $error("clip_w: expected %0d, got %0d", want.clip_w, got.clip_w);
      errors++;
    end
    if (got.in_front !== want.in_front) begin
      $error("in_front: expected %0b, got %0b", want.in_front, got.in_front);
      errors++;
    end
    if (got.w_zero !== want.w_zero) begin
      $error("w_zero: expected %0b, got %0b", want.w_zero, got.w_zero);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      check_result(out_word_o);
      stall_left = $urandom_range(0, take_idle_max);
    end else if (stall_left != 0) begin
      stall_left--;
    end
    out_stall_i <= (stall_left != 0);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("perspective_world_to_screen: mismatch");
      $finish;
    end
  end

  function automatic logic signed [31:0] rand_q16();
    case ($urandom_range(0, 7))
      0, 1: return $urandom;
      2: begin
        case ($urandom_range(0, 4))
          0: return pws_pkg::S32_MAX;
          1: return pws_pkg::S32_MIN;
          2: return 32'sd0;
          3: return ONE_Q;
          default: return -ONE_Q;
        endcase
      end
      default: return int'($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
    endcase
  endfunction

  function automatic logic [pws_pkg::DIM_W-1:0] rand_dim();
    case ($urandom_range(0, 5))
      0: return 13'd1;
      1: return 13'd4096;
      2: return 13'd0;
      3: return 13'h1fff;
      default: return pws_pkg::DIM_W'($urandom_range(1, 4096));
    endcase
  endfunction

  function automatic pws_pkg::pws_in_t load_word(logic [3:0] slot, logic signed [31:0] value);
    pws_pkg::pws_in_t word;
    word.func = pws_pkg::FUNC_LOAD;
    word.coef_index = slot;
    word.coef_value = value;
    word.pos_x = $urandom;
    word.pos_y = $urandom;
    word.pos_z = $urandom;
    return word;
  endfunction

  function automatic pws_pkg::pws_in_t point_word(logic signed [31:0] x,
                                                  logic signed [31:0] y,
                                                  logic signed [31:0] z);
    pws_pkg::pws_in_t word;
    word.func = pws_pkg::FUNC_PROJECT;
    word.coef_index = $urandom;
    word.coef_value = $urandom;
    word.pos_x = x;
    word.pos_y = y;
    word.pos_z = z;
    return word;
  endfunction

  task automatic send_word(input pws_pkg::pws_in_t word);
    int unsigned gap;
    gap = $urandom_range(0, send_idle_max);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i <= word;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    absorb_word(word);
  endtask

  task automatic send_random_word();
    logic [3:0] slot;
    if ($urandom_range(0, 99) < 35) begin
      slot = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(12, 15))
                                         : 4'($urandom_range(0, 11));
      send_word(load_word(slot, rand_q16()));
    end else begin
      send_word(point_word(rand_q16(), rand_q16(), rand_q16()));
    end
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_screen_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_viewport(logic [pws_pkg::DIM_W-1:0] wd, logic [pws_pkg::DIM_W-1:0] ht);
    wait_idle();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= pws_pkg::CFG_WIDTH;
    cfg_data_i <= wd;
    @(posedge clk_i);
    view_width = wd;
    cfg_idx_i <= pws_pkg::CFG_HEIGHT;
    cfg_data_i <= ht;
    @(posedge clk_i);
    view_height = ht;
    cfg_we_i <= 1'b0;
    viewports_set++;
  endtask

  // zero store gives w of zero, then default 800x600 viewport
  task automatic test_reset_defaults();
    send_word(point_word(ONE_Q, 2 * ONE_Q, 3 * ONE_Q));
    send_word(load_word(4'd13, 32'sh1234_5678));
    send_word(load_word(4'd11, ONE_Q));
    send_word(load_word(4'd3, HALF_Q));
    send_word(point_word(-ONE_Q, ONE_Q, pws_pkg::S32_MIN));
  endtask

  task automatic test_directed_projection();
    send_word(load_word(4'd0, ONE_Q));
    send_word(load_word(4'd5, ONE_Q));
    send_word(load_word(4'd10, ONE_Q));
    send_word(load_word(4'd3, 32'sd0));
    send_word(load_word(4'd11, 32'sd0));
    send_word(point_word(HALF_Q, -HALF_Q, ONE_Q));
    send_word(point_word(-ONE_Q, -ONE_Q, 32'sd0));
    send_word(point_word(ONE_Q, ONE_Q, -2 * ONE_Q));
    send_word(point_word(32'sd0, 32'sd0, 32'sd655));
    send_word(point_word(32'sd0, 32'sd0, 32'sd656));
    send_word(point_word(pws_pkg::S32_MAX, pws_pkg::S32_MIN, ONE_Q));
    send_word(point_word(pws_pkg::S32_MIN, pws_pkg::S32_MAX, 32'sd1));
    // saturating clip x
    send_word(load_word(4'd0, pws_pkg::S32_MAX));
    send_word(load_word(4'd1, pws_pkg::S32_MAX));
    send_word(load_word(4'd2, pws_pkg::S32_MAX));
    send_word(load_word(4'd15, pws_pkg::S32_MIN));
    send_word(point_word(pws_pkg::S32_MAX, pws_pkg::S32_MAX, pws_pkg::S32_MAX));
  endtask

  task automatic test_viewport_extremes();
    logic [pws_pkg::DIM_W-1:0] sizes [5];
    sizes = '{13'd1, 13'd4096, 13'd0, 13'h1fff, 13'd1};
    for (int i = 0; i < 5; i++) begin
      set_viewport(sizes[i], (i == 4) ? 13'd4096 : sizes[i]);
      repeat (16) send_random_word();
    end
  endtask

  task automatic test_random_traffic();
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i % 325 == 0) set_viewport(rand_dim(), rand_dim());
      if (i % 100 == 0) begin
        send_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 13;
        take_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 13;
      end
      send_random_word();
    end
  endtask

  initial begin
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    in_word_i <= '0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= pws_pkg::CFG_WIDTH;
    cfg_data_i <= '0;
    for (int i = 0; i < pws_pkg::NUM_COEFS; i++) view_coef[i] = '0;
    view_width = pws_pkg::WIDTH_RST;
    view_height = pws_pkg::HEIGHT_RST;
    send_idle_max = 13;
    take_idle_max = 13;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_directed_projection();
    test_viewport_extremes();
    test_random_traffic();

    send_idle_max = 13;
    take_idle_max = 13;
    wait_idle();
    $display("%0d points projected, %0d coefficient loads, %0d viewport settings",
             points_sent, loads_sent, viewports_set);
    $display("idle and stall gaps of 0 to 13 cycles on both channels, %0d errors", errors);
    if (errors == 0) begin
      $display("perspective_world_to_screen: match");
    end else begin
      $display("perspective_world_to_screen: mismatch");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/pws_pkg.sv
hw/rtl/pws_div.sv
hw/rtl/pws_ctrl.sv
hw/rtl/perspective_world_to_screen.sv
tb/sv/perspective_world_to_screen_tb.sv
